// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the PS/2 mouse decoder RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every rising edge outside reset
`define PSMD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("psmd assertion failed");

// Condition that must never be true outside reset
`define PSMD_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("psmd forbidden condition seen");

`else

`define PSMD_ASSERT(label, clk, rst, prop)
`define PSMD_NEVER(label, clk, rst, cond)

`endif

`endif

// File: hw/rtl/psmd_pkg.sv
// Shared types and constants for the PS/2 mouse packet decoder.
// No dependencies.
`timescale 1ns / 1ps

package psmd_pkg;

  // Buttons that are reported (left, right, middle)
  localparam int NUM_BUTTONS = 3;
  localparam logic [2:0] BTN_EN = 3'((1 << NUM_BUTTONS) - 1);

  // Packet queue depth between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [31:0] DCLICK_RESET = 32'd3000;

  typedef enum logic [1:0] {
    EV_MOVED    = 2'd0,
    EV_DOUBLE   = 2'd1,
    EV_CLICKED  = 2'd2,
    EV_RELEASED = 2'd3
  } event_kind_t;

  // Everything one complete packet asks the back end to emit
  typedef struct packed {
    logic              mv;
    logic signed [8:0] mx;
    logic signed [9:0] my;
    logic [1:0]        ndbl;
    logic [2:0]        clicks;
    logic [2:0]        releases;
  } pkt_desc_t;

  typedef struct packed {
    logic      push;
    pkt_desc_t desc;
  } pkt_push_t;

endpackage

// File: hw/rtl/psmd_front.sv
// Front end: accepts mouse bytes, tracks packet phase and button history,
// and classifies each finished packet into a descriptor. Uses psmd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psmd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [31:0]          cfg_write_data,
  input  logic                 accept,
  input  logic                 aux_data_ready,
  input  logic [7:0]           data_byte,
  input  logic [31:0]          now_time,
  output psmd_pkg::pkt_push_t  pkt
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_X      = 3'b010,
    PH_Y      = 3'b100
  } phase_t;

  // Where last_click_time stands while walking the buttons
  typedef enum logic [1:0] {
    LC_ORIG = 2'd0,
    LC_ZERO = 2'd1,
    LC_NOW  = 2'd2
  } lc_src_t;

  phase_t      phase, phase_next;
  logic [7:0]  header_flags, header_flags_next;
  logic [8:0]  pending_x, pending_x_next;
  logic [2:0]  previous_buttons, previous_buttons_next;
  logic [31:0] last_click_time, last_click_time_next;
  logic [31:0] double_click_window;

  logic [8:0]  y9;
  logic [9:0]  dy;
  logic [2:0]  changed, clicks, releases;
  logic        hit_orig, hit_zero, hit_now, hit;
  lc_src_t     lc_src;
  logic [1:0]  ndbl;
  logic        mv;

  // Window register
  always_ff @(posedge clk) begin
    if (rst) begin
      double_click_window <= psmd_pkg::DCLICK_RESET;
    end else if (cfg_write_en) begin
      double_click_window <= cfg_write_data;
    end
  end

  // Packet fields and button comparisons for the Y byte
  assign y9       = {header_flags[5], data_byte};
  assign dy       = 10'd0 - {y9[8], y9};
  assign changed  = header_flags[2:0] ^ previous_buttons;
  assign clicks   = changed & ~previous_buttons & psmd_pkg::BTN_EN;
  assign releases = changed & previous_buttons & psmd_pkg::BTN_EN;
  assign mv       = (header_flags[7:6] == 2'b00) && ((pending_x != 9'd0) || (y9 != 9'd0));

  // The three possible values of the stored click time give three flat compares
  assign hit_orig = (now_time - last_click_time) < double_click_window;
  assign hit_zero = now_time < double_click_window;
  assign hit_now  = double_click_window != 32'd0;

  // Walk pressed buttons in order left, right, middle
  always_comb begin
    lc_src = LC_ORIG;
    ndbl   = 2'd0;
    hit    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (clicks[i]) begin
        case (lc_src)
          LC_ORIG: hit = hit_orig;
          LC_ZERO: hit = hit_zero;
          LC_NOW:  hit = hit_now;
          default: hit = hit_orig;
        endcase
        if (hit) begin
          ndbl   = ndbl + 2'd1;
          lc_src = LC_ZERO;
        end else begin
          lc_src = LC_NOW;
        end
      end
    end
  end

  // Next state and descriptor push
  always_comb begin
    phase_next            = phase;
    header_flags_next     = header_flags;
    pending_x_next        = pending_x;
    previous_buttons_next = previous_buttons;
    last_click_time_next  = last_click_time;
    pkt.push              = 1'b0;
    pkt.desc.mv           = mv;
    pkt.desc.mx           = $signed(pending_x);
    pkt.desc.my           = $signed(dy);
    pkt.desc.ndbl         = ndbl;
    pkt.desc.clicks       = clicks;
    pkt.desc.releases     = releases;
    if (accept && aux_data_ready) begin
      case (phase)
        PH_X: begin
          pending_x_next = {header_flags[4], data_byte};
          phase_next     = PH_Y;
        end
        PH_Y: begin
          pkt.push              = mv || (clicks != 3'd0) || (releases != 3'd0);
          previous_buttons_next = header_flags[2:0];
          phase_next            = PH_HEADER;
          case (lc_src)
            LC_ZERO: last_click_time_next = 32'd0;
            LC_NOW:  last_click_time_next = now_time;
            default: last_click_time_next = last_click_time;
          endcase
        end
        default: begin
          header_flags_next = data_byte;
          phase_next        = data_byte[3] ? PH_X : PH_HEADER;
        end
      endcase
    end
  end

  // Hold packet state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      header_flags     <= 8'd0;
      pending_x        <= 9'd0;
      previous_buttons <= 3'd0;
      last_click_time  <= 32'd0;
    end else begin
      phase            <= phase_next;
      header_flags     <= header_flags_next;
      pending_x        <= pending_x_next;
      previous_buttons <= previous_buttons_next;
      last_click_time  <= last_click_time_next;
    end
  end

  `PSMD_ASSERT(a_dbl_needs_click, clk, rst, pkt.push |-> (pkt.desc.ndbl <= 2'($countones(pkt.desc.clicks))))
  `PSMD_ASSERT(a_header_after_y, clk, rst, (accept && aux_data_ready && phase == PH_Y) |=> (phase == PH_HEADER))

endmodule

// File: hw/rtl/psmd_queue.sv
// Short descriptor queue between front and back end.
// Uses psmd_pkg for the descriptor type and depth.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psmd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  psmd_pkg::pkt_push_t  wr,
  input  logic                 pop,
  output psmd_pkg::pkt_desc_t  head,
  output logic                 empty,
  output logic                 full
);

  psmd_pkg::pkt_desc_t entries [psmd_pkg::QDEPTH];

  logic [psmd_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [psmd_pkg::QCNT_W-1:0] count;

  assign empty = count == '0;
  assign full  = count == psmd_pkg::QCNT_W'(psmd_pkg::QDEPTH);
  assign head  = entries[rd_ptr];

  // Store pushed descriptors
  always_ff @(posedge clk) begin
    if (wr.push) begin
      entries[wr_ptr] <= wr.desc;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr.push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !wr.push) begin
        count <= count - 1'b1;
      end
    end
  end

  `PSMD_NEVER(a_no_overflow, clk, rst, wr.push && full)
  `PSMD_NEVER(a_no_underflow, clk, rst, pop && empty)

endmodule

// File: hw/rtl/psmd_back.sv
// Back end: expands the queued packet descriptor into events, one per cycle
// while out_ready allows, into a registered output stage. Uses psmd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psmd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  psmd_pkg::pkt_desc_t  head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           event_kind,
  output logic signed [8:0]    move_x,
  output logic signed [9:0]    move_y,
  output logic [2:0]           button_mask,
  output logic                 last_of_run
);

  logic       mv_sent, clk_sent;
  logic [1:0] dbl_sent;

  logic                  rem_mv, rem_dbl, rem_clk, load, ev_last;
  psmd_pkg::event_kind_t ev_kind;
  logic signed [8:0]     ev_mx;
  logic signed [9:0]     ev_my;
  logic [2:0]            ev_mask;
  logic [1:0]            dbl_inc;

  assign rem_mv  = head.mv && !mv_sent;
  assign rem_dbl = dbl_sent != head.ndbl;
  assign rem_clk = (head.clicks != 3'd0) && !clk_sent;
  assign dbl_inc = dbl_sent + 2'd1;
  assign load    = !empty && (!out_valid || out_ready);
  assign pop     = load && ev_last;

  // Pick the next event of the head packet
  always_comb begin
    ev_kind = psmd_pkg::EV_RELEASED;
    ev_mx   = 9'sd0;
    ev_my   = 10'sd0;
    ev_mask = head.releases;
    ev_last = 1'b1;
    if (rem_mv) begin
      ev_kind = psmd_pkg::EV_MOVED;
      ev_mx   = head.mx;
      ev_my   = head.my;
      ev_mask = 3'd0;
      ev_last = (head.ndbl == 2'd0) && (head.clicks == 3'd0) && (head.releases == 3'd0);
    end else if (rem_dbl) begin
      ev_kind = psmd_pkg::EV_DOUBLE;
      ev_mask = 3'd0;
      ev_last = (dbl_inc == head.ndbl) && (head.clicks == 3'd0) && (head.releases == 3'd0);
    end else if (rem_clk) begin
      ev_kind = psmd_pkg::EV_CLICKED;
      ev_mask = head.clicks;
      ev_last = head.releases == 3'd0;
    end
  end

  // Track progress through the head packet
  always_ff @(posedge clk) begin
    if (rst) begin
      mv_sent  <= 1'b0;
      dbl_sent <= 2'd0;
      clk_sent <= 1'b0;
    end else if (load) begin
      if (ev_last) begin
        mv_sent  <= 1'b0;
        dbl_sent <= 2'd0;
        clk_sent <= 1'b0;
      end else if (rem_mv) begin
        mv_sent <= 1'b1;
      end else if (rem_dbl) begin
        dbl_sent <= dbl_inc;
      end else begin
        clk_sent <= 1'b1;
      end
    end
  end

  // Output stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output stage payload
  always_ff @(posedge clk) begin
    if (load) begin
      event_kind  <= ev_kind;
      move_x      <= ev_mx;
      move_y      <= ev_my;
      button_mask <= ev_mask;
      last_of_run <= ev_last;
    end
  end

  `PSMD_ASSERT(a_head_has_work, clk, rst,
    !empty |-> (head.mv || head.clicks != 3'd0 || head.releases != 3'd0))
  `PSMD_NEVER(a_dbl_in_range, clk, rst, !empty && dbl_sent > head.ndbl)

endmodule

// File: hw/rtl/ps2_mouse_packet_decoder_unit.sv
// Top level of the PS/2 mouse packet decoder.
// Depends on psmd_pkg, psmd_front, psmd_queue and psmd_back.
`timescale 1ns / 1ps

// Usage:
// Input channel (in_valid/in_ready) takes one byte per transaction with its
// aux_data_ready flag and a millisecond timestamp now_time. Bytes without
// the flag are taken and dropped. Header, X and Y bytes form a packet; a
// header lacking bit 3 is dropped and the decoder keeps waiting for a header.
// Throughput: one input byte per cycle while the packet queue has room.
// When the Y byte of a packet that reports a move or a button change is
// taken, the front end writes one descriptor into a four-entry queue; the
// back end turns it into up to five events, one per cycle while out_ready
// allows, on the output channel (out_valid/out_ready), each event going out
// via the output register; last_of_run marks the packet's final event.
// If the receiver stalls, the output register holds its event, the queue
// fills, and in_ready drops only once all four queue entries are occupied.
// cfg_write_en/cfg_write_data load the double click window (ticks), to be
// written while the block is idle.
// Reset (rst, synchronous) empties the queue and output stage, returns the
// decoder to waiting for a header, clears button history and click time,
// and sets the window to 3000.
module ps2_mouse_packet_decoder_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [31:0]       cfg_write_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              aux_data_ready,
  input  logic [7:0]        data_byte,
  input  logic [31:0]       now_time,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        event_kind,
  output logic signed [8:0] move_x,
  output logic signed [9:0] move_y,
  output logic [2:0]        button_mask,
  output logic              last_of_run
);

  psmd_pkg::pkt_push_t pkt;
  psmd_pkg::pkt_desc_t head;
  logic                empty, full, pop;

  assign in_ready = !full;

  psmd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .accept         (in_valid && in_ready),
    .aux_data_ready (aux_data_ready),
    .data_byte      (data_byte),
    .now_time       (now_time),
    .pkt            (pkt)
  );

  psmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (pkt),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .full  (full)
  );

  psmd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .move_x      (move_x),
    .move_y      (move_y),
    .button_mask (button_mask),
    .last_of_run (last_of_run)
  );

endmodule
